// ===== hw/rtl/bleadv_pkg.sv =====
// ----------------------------------------------------------------------------
// bleadv_pkg
// Shared types and constants for the BLE advertising data field extractor.
// ----------------------------------------------------------------------------
package bleadv_pkg;

	// AD structure type codes
	localparam logic [7:0] AD_FLAGS      = 8'h01;
	localparam logic [7:0] AD_NAME_SHORT = 8'h08;
	localparam logic [7:0] AD_NAME_FULL  = 8'h09;
	localparam logic [7:0] AD_TX_POWER   = 8'h0A;
	localparam logic [7:0] AD_MFG_DATA   = 8'hFF;

	// configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_FLAGS_DEF   = 2'd0;
	localparam cfg_idx_t CFG_POWER_DEF   = 2'd1;
	localparam cfg_idx_t CFG_COMPANY_DEF = 2'd2;

	typedef logic [15:0] cfg_data_t;
	typedef logic [5:0]  name_len_t;

endpackage : bleadv_pkg

// ===== hw/rtl/bleadv_if.sv =====
// ----------------------------------------------------------------------------
// bleadv channel interfaces
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface bleadv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ad_byte;
	logic       last_byte;
	logic       empty_report;

	modport source (output valid, ad_byte, last_byte, empty_report, input ready);
	modport sink   (input valid, ad_byte, last_byte, empty_report, output ready);
endinterface : bleadv_in_if

interface bleadv_out_if;
	logic                  valid;
	logic                  ready;
	logic                  is_summary;
	logic [7:0]            name_char;
	logic [7:0]            flags_value;
	logic signed [7:0]     tx_dbm;
	logic [15:0]           company_code;
	bleadv_pkg::name_len_t name_length;
	logic                  last_result;

	modport source (output valid, is_summary, name_char, flags_value, tx_dbm,
		company_code, name_length, last_result, input ready);
	modport sink   (input valid, is_summary, name_char, flags_value, tx_dbm,
		company_code, name_length, last_result, output ready);
endinterface : bleadv_out_if

interface bleadv_cfg_if;
	logic                  valid;
	logic                  ready;
	bleadv_pkg::cfg_idx_t  index;
	bleadv_pkg::cfg_data_t data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface : bleadv_cfg_if

// ===== hw/rtl/ble_adv_data_field_extractor_core.sv =====
// ----------------------------------------------------------------------------
// ble_adv_data_field_extractor_core
// Parses BLE advertising data one byte per request and reports flags,
// TX power, company ID and the first local name of each report.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+------------
//  ad      | in  | ad_byte, last_byte, empty_report          | valid/ready
//  res     | out | is_summary, name_char, flags_value,       | valid/ready
//          |     | tx_dbm, company_code, name_length,        |
//          |     | last_result                               |
//  cfg     | in  | index, data (register write)              | valid/ready
//
//  - One byte request per cycle while parsing; each byte is folded into the
//    parse state in the cycle it is taken.
//  - The last byte of a report starts a drain: the captured name bytes, read
//    from the name RAM (synchronous read), then the summary, leave one per
//    cycle while the res sink does not stall.
//  - ad.ready is low only during the drain; res is held in an output
//    register, so a stalled sink holds the drain, never a pending result.
//  - arst_n clears all control state; no clearing pass, the name RAM is
//    only read below the fill count.
//
module ble_adv_data_field_extractor_core #(
	parameter int NAME_LEN = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	bleadv_in_if.sink     ad,
	bleadv_out_if.source  res,
	bleadv_cfg_if.sink    cfg
);
	import bleadv_pkg::*;

	localparam int NAME_CAP = NAME_LEN - 1;
	localparam int AW       = $clog2(NAME_LEN);
	localparam logic [AW-1:0] CAP_CNT = AW'(NAME_CAP);

	// parse phase codes
	localparam logic [1:0] PH_LENGTH = 2'd0;
	localparam logic [1:0] PH_TYPE   = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;
	localparam logic [1:0] PH_STOP   = 2'd3;

	// data index saturates at 2: only first, second and "later" matter
	localparam logic [1:0] IDX_SAT = 2'd2;

	// parse state
	logic [1:0]    phase_q, phase_d;
	logic [7:0]    bytes_left_q, bytes_left_d;
	logic [7:0]    field_type_q, field_type_d;
	logic [1:0]    data_idx_q, data_idx_d;
	logic [AW-1:0] name_cnt_q, name_cnt_d;
	logic          capturing_q, capturing_d;
	logic [7:0]    flags_hold_q, flags_hold_d;
	logic [7:0]    power_hold_q, power_hold_d;
	logic [15:0]   company_hold_q, company_hold_d;
	logic [7:0]    company_lo_q, company_lo_d;
	logic          in_report_q;

	// register defaults
	logic [7:0]    flags_def_q;
	logic [7:0]    power_def_q;
	logic [15:0]   company_def_q;

	// drain and name RAM
	logic          drain_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] rd_addr;
	logic [7:0]    name_rd_q;
	logic [7:0]    name_mem [NAME_LEN];
	logic          name_we;

	// output register
	logic          res_valid_q;
	logic          res_is_summary_q;
	logic [7:0]    res_name_char_q;
	logic [7:0]    res_flags_q;
	logic [7:0]    res_power_q;
	logic [15:0]   res_company_q;
	name_len_t     res_name_len_q;

	logic ad_take, byte_take, report_end, cfg_take;
	logic out_free, drain_step, name_pending, drain_end;
	logic [7:0] bl_m1;

	assign ad.ready   = !drain_q;
	assign cfg.ready  = 1'b1;
	assign ad_take    = ad.valid && ad.ready;
	assign byte_take  = ad_take && !ad.empty_report;
	assign report_end = ad_take && ad.last_byte;
	assign cfg_take   = cfg.valid && cfg.ready;

	assign out_free     = !res_valid_q || res.ready;
	assign drain_step   = drain_q && out_free;
	assign name_pending = rd_ptr_q != name_cnt_q;
	// summary goes out on this edge
	assign drain_end    = drain_step && !name_pending;

	assign bl_m1 = bytes_left_q - 8'd1;

	// per-byte parse
	always_comb begin
		phase_d        = phase_q;
		bytes_left_d   = bytes_left_q;
		field_type_d   = field_type_q;
		data_idx_d     = data_idx_q;
		name_cnt_d     = name_cnt_q;
		capturing_d    = capturing_q;
		flags_hold_d   = flags_hold_q;
		power_hold_d   = power_hold_q;
		company_hold_d = company_hold_q;
		company_lo_d   = company_lo_q;
		name_we        = 1'b0;
		if (byte_take) begin
			unique case (phase_q)
				PH_LENGTH: begin
					if (ad.ad_byte == 8'd0) begin
						phase_d = PH_STOP;
					end else begin
						bytes_left_d = ad.ad_byte;
						phase_d      = PH_TYPE;
					end
				end
				PH_TYPE: begin
					field_type_d = ad.ad_byte;
					data_idx_d   = 2'd0;
					bytes_left_d = bl_m1;
					capturing_d  = (ad.ad_byte == AD_NAME_SHORT || ad.ad_byte == AD_NAME_FULL)
						&& name_cnt_q == '0;
					phase_d      = (bl_m1 == 8'd0) ? PH_LENGTH : PH_DATA;
				end
				PH_DATA: begin
					if (field_type_q == AD_FLAGS && data_idx_q == 2'd0) begin
						flags_hold_d = ad.ad_byte;
					end else if (field_type_q == AD_TX_POWER && data_idx_q == 2'd0) begin
						power_hold_d = ad.ad_byte;
					end else if (field_type_q == AD_MFG_DATA && data_idx_q == 2'd0) begin
						company_lo_d = ad.ad_byte;
					end else if (field_type_q == AD_MFG_DATA && data_idx_q == 2'd1) begin
						company_hold_d = {ad.ad_byte, company_lo_q};
					end
					if (capturing_q && name_cnt_q < CAP_CNT) begin
						name_we    = 1'b1;
						name_cnt_d = name_cnt_q + 1'b1;
					end
					if (data_idx_q != IDX_SAT) begin
						data_idx_d = data_idx_q + 2'd1;
					end
					bytes_left_d = bl_m1;
					if (bl_m1 == 8'd0) begin
						capturing_d = 1'b0;
						phase_d     = PH_LENGTH;
					end
				end
				PH_STOP: begin
					// zero length seen: ignore the rest of the report
				end
			endcase
		end

		// back to defaults for the next report
		if (drain_end) begin
			phase_d        = PH_LENGTH;
			bytes_left_d   = '0;
			field_type_d   = '0;
			data_idx_d     = '0;
			name_cnt_d     = '0;
			capturing_d    = 1'b0;
			flags_hold_d   = flags_def_q;
			power_hold_d   = power_def_q;
			company_hold_d = company_def_q;
			company_lo_d   = '0;
		end

		// a write between reports also reloads the live value
		if (cfg_take && !in_report_q) begin
			unique case (cfg.index)
				CFG_FLAGS_DEF:   flags_hold_d   = cfg.data[7:0];
				CFG_POWER_DEF:   power_hold_d   = cfg.data[7:0];
				CFG_COMPANY_DEF: company_hold_d = cfg.data;
				default: begin
				end
			endcase
		end
	end

	// read the next entry as soon as the current one is taken
	assign rd_addr = (drain_step && name_pending) ? rd_ptr_q + 1'b1 : rd_ptr_q;

	// name RAM, write-through so a name byte on the last request is seen
	always_ff @(posedge clk) begin
		if (name_we) begin
			name_mem[name_cnt_q] <= ad.ad_byte;
		end
		name_rd_q <= (name_we && name_cnt_q == rd_addr) ? ad.ad_byte : name_mem[rd_addr];
	end

	// control and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_LENGTH;
			bytes_left_q   <= '0;
			field_type_q   <= '0;
			data_idx_q     <= '0;
			name_cnt_q     <= '0;
			capturing_q    <= 1'b0;
			flags_hold_q   <= 8'd0;
			power_hold_q   <= 8'd127;
			company_hold_q <= 16'hFFFF;
			company_lo_q   <= '0;
			in_report_q    <= 1'b0;
			flags_def_q    <= 8'd0;
			power_def_q    <= 8'd127;
			company_def_q  <= 16'hFFFF;
			drain_q        <= 1'b0;
			rd_ptr_q       <= '0;
		end else begin
			phase_q        <= phase_d;
			bytes_left_q   <= bytes_left_d;
			field_type_q   <= field_type_d;
			data_idx_q     <= data_idx_d;
			name_cnt_q     <= name_cnt_d;
			capturing_q    <= capturing_d;
			flags_hold_q   <= flags_hold_d;
			power_hold_q   <= power_hold_d;
			company_hold_q <= company_hold_d;
			company_lo_q   <= company_lo_d;

			if (byte_take) begin
				in_report_q <= 1'b1;
			end else if (drain_end) begin
				in_report_q <= 1'b0;
			end

			if (report_end) begin
				drain_q <= 1'b1;
			end else if (drain_end) begin
				drain_q <= 1'b0;
			end

			if (drain_step) begin
				rd_ptr_q <= name_pending ? rd_ptr_q + 1'b1 : '0;
			end

			if (cfg_take) begin
				unique case (cfg.index)
					CFG_FLAGS_DEF:   flags_def_q   <= cfg.data[7:0];
					CFG_POWER_DEF:   power_def_q   <= cfg.data[7:0];
					CFG_COMPANY_DEF: company_def_q <= cfg.data;
					default: begin
					end
				endcase
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (drain_step) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (drain_step) begin
			if (name_pending) begin
				res_is_summary_q <= 1'b0;
				res_name_char_q  <= name_rd_q;
				res_flags_q      <= '0;
				res_power_q      <= '0;
				res_company_q    <= '0;
				res_name_len_q   <= '0;
			end else begin
				res_is_summary_q <= 1'b1;
				res_name_char_q  <= '0;
				res_flags_q      <= flags_hold_q;
				res_power_q      <= power_hold_q;
				res_company_q    <= company_hold_q;
				res_name_len_q   <= name_len_t'(name_cnt_q);
			end
		end
	end

	assign res.valid        = res_valid_q;
	assign res.is_summary   = res_is_summary_q;
	assign res.name_char    = res_name_char_q;
	assign res.flags_value  = res_flags_q;
	assign res.tx_dbm       = res_power_q;
	assign res.company_code = res_company_q;
	assign res.name_length  = res_name_len_q;
	assign res.last_result  = res_is_summary_q;

endmodule : ble_adv_data_field_extractor_core

// ===== hw/rtl/bleadv_checker.sv =====
// ----------------------------------------------------------------------------
// bleadv_checker
// Port-level checks for the advertising data field extractor.
// ----------------------------------------------------------------------------
module bleadv_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  ad_valid,
	input logic                  ad_ready,
	input logic                  ad_last,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic                  res_is_summary,
	input logic                  res_last_result,
	input logic [7:0]            res_name_char,
	input logic [15:0]           res_company,
	input bleadv_pkg::name_len_t res_name_length
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_is_summary)
			&& $stable(res_name_char) && $stable(res_name_length))
		else $error("result changed while stalled");

	// the end of a report always starts a drain
	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		ad_valid && ad_ready && ad_last |=> !ad_ready)
		else $error("byte request taken right after report end");

	a_summary_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_is_summary == res_last_result)
		else $error("last_result disagrees with item kind");

	a_name_item_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_is_summary |-> res_name_length == '0 && res_company == '0)
		else $error("name item carries summary fields");

endmodule : bleadv_checker

bind ble_adv_data_field_extractor_core bleadv_checker u_bleadv_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.ad_valid        (ad.valid),
	.ad_ready        (ad.ready),
	.ad_last         (ad.last_byte),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_is_summary  (res.is_summary),
	.res_last_result (res.last_result),
	.res_name_char   (res.name_char),
	.res_company     (res.company_code),
	.res_name_length (res.name_length)
);

// ===== tb/ble_adv_data_field_extractor_core_tb.sv =====
// ----------------------------------------------------------------------------
// ble_adv_data_field_extractor_core_tb
// Self-checking bench for the advertising data field extractor. Feeds whole
// advertising reports byte by byte, and keeps its own parser model that
// predicts the name bytes and the summary of each report. Each result from
// the core is checked field by field against the oldest prediction.
// Directed reports come first, then register extremes, then random reports
// with random idle on both sides, and a final burst with no idling.
// ----------------------------------------------------------------------------
module ble_adv_data_field_extractor_core_tb;
	import bleadv_pkg::*;

	localparam int NAME_LEN    = 32;
	localparam int NAME_CAP    = NAME_LEN - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 27;
	localparam int MAX_SHOWN   = 10;

	// parser phases of the model
	typedef enum logic [1:0] {
		SEEK_LEN  = 2'd0,
		SEEK_TYPE = 2'd1,
		IN_DATA   = 2'd2,
		HALTED    = 2'd3
	} parse_ph_e;

	// one byte request
	typedef struct packed {
		logic [7:0] b;
		logic       lst;
		logic       emp;
	} ad_item_t;

	// one result item; tx_dbm kept as raw bits, shown signed
	typedef struct packed {
		logic       is_summary;
		logic [7:0] name_char;
		logic [7:0] flags_value;
		logic [7:0] tx_dbm;
		logic [15:0] company_code;
		name_len_t  name_length;
		logic       last_result;
	} adv_result_t;

	typedef logic [7:0] byte_seq_t[];

	logic clk = 1'b0;
	logic arst_n;

	bleadv_in_if  ad_if();
	bleadv_out_if res_if();
	bleadv_cfg_if cfg_if();

	ble_adv_data_field_extractor_core #(
		.NAME_LEN(NAME_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.ad(ad_if),
		.res(res_if),
		.cfg(cfg_if)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// parser model state
	// ------------------------------------------------------------------------
	logic [7:0]  dflt_flags;
	logic [7:0]  dflt_power;
	logic [15:0] dflt_company;

	parse_ph_e   parse_ph;
	logic [7:0]  len_left;
	logic [7:0]  cur_type;
	logic [7:0]  data_pos;
	logic [7:0]  name_buf [NAME_CAP];
	logic [5:0]  name_cnt;
	logic        grab_name;
	logic [7:0]  seen_flags;
	logic [7:0]  seen_power;
	logic [15:0] seen_company;
	logic [7:0]  company_lo;
	logic        report_open;

	adv_result_t due_results[$];	// predicted, not yet seen
	ad_item_t    stage_q[$];		// report being assembled

	bit no_gaps = 1'b0;
	int cycles = 0;
	int mismatches = 0;
	int results_seen = 0;
	int bytes_sent = 0;
	int reports_sent = 0;
	int reg_writes = 0;

	// back to defaults, ready for a new report
	function automatic void open_report();
		parse_ph     = SEEK_LEN;
		len_left     = '0;
		cur_type     = '0;
		data_pos     = '0;
		name_cnt     = '0;
		grab_name    = 1'b0;
		seen_flags   = dflt_flags;
		seen_power   = dflt_power;
		seen_company = dflt_company;
		company_lo   = '0;
		report_open  = 1'b0;
	endfunction

	// fold one length / type / data byte into the parse state
	function automatic void parse_ad_byte(input logic [7:0] b);
		case (parse_ph)
		SEEK_LEN: begin
			// a zero length ends parsing for the rest of the report
			if (b == 8'h00) begin
				parse_ph = HALTED;
			end else begin
				len_left = b;
				parse_ph = SEEK_TYPE;
			end
		end
		SEEK_TYPE: begin
			cur_type  = b;
			data_pos  = '0;
			len_left  = len_left - 8'd1;
			// only the first name structure with data is captured
			grab_name = (b == AD_NAME_SHORT || b == AD_NAME_FULL) && name_cnt == 0;
			parse_ph  = (len_left == 0) ? SEEK_LEN : IN_DATA;
		end
		IN_DATA: begin
			if (cur_type == AD_FLAGS && data_pos == 0) begin
				seen_flags = b;
			end else if (cur_type == AD_TX_POWER && data_pos == 0) begin
				seen_power = b;
			end else if (cur_type == AD_MFG_DATA && data_pos == 0) begin
				company_lo = b;
			end else if (cur_type == AD_MFG_DATA && data_pos == 1) begin
				seen_company = {b, company_lo};
			end
			if (grab_name && name_cnt < NAME_CAP) begin
				name_buf[name_cnt] = b;
				name_cnt = name_cnt + 6'd1;
			end
			if (data_pos != 8'hFF) data_pos = data_pos + 8'd1;
			len_left = len_left - 8'd1;
			if (len_left == 0) begin
				grab_name = 1'b0;
				parse_ph  = SEEK_LEN;
			end
		end
		default: ;
		endcase
	endfunction

	// accepted request -> predicted results (name bytes, then summary)
	function automatic void predict_request(input ad_item_t it);
		adv_result_t r;
		if (!it.emp) begin
			report_open = 1'b1;
			parse_ad_byte(it.b);
		end
		if (it.lst) begin
			for (int i = 0; i < name_cnt; i++) begin
				r = '0;
				r.name_char = name_buf[i];
				due_results.push_back(r);
			end
			r = '0;
			r.is_summary   = 1'b1;
			r.flags_value  = seen_flags;
			r.tx_dbm       = seen_power;
			r.company_code = seen_company;
			r.name_length  = name_cnt;
			r.last_result  = 1'b1;
			due_results.push_back(r);
			open_report();
		end
	endfunction

	function automatic void apply_reg(input cfg_idx_t idx, input cfg_data_t v);
		case (idx)
		CFG_FLAGS_DEF: begin
			dflt_flags = v[7:0];
			if (!report_open) seen_flags = dflt_flags;
		end
		CFG_POWER_DEF: begin
			dflt_power = v[7:0];
			if (!report_open) seen_power = dflt_power;
		end
		CFG_COMPANY_DEF: begin
			dflt_company = v;
			if (!report_open) seen_company = dflt_company;
		end
		default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// result side: random stall, checker
	// ------------------------------------------------------------------------
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		adv_result_t got, want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.is_summary   = res_if.is_summary;
			got.name_char    = res_if.name_char;
			got.flags_value  = res_if.flags_value;
			got.tx_dbm       = res_if.tx_dbm;
			got.company_code = res_if.company_code;
			got.name_length  = res_if.name_length;
			got.last_result  = res_if.last_result;
			results_seen++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result: sum=%0b char=%02h flags=%02h pwr=%0d co=%04h len=%0d",
						got.is_summary, got.name_char, got.flags_value,
						$signed(got.tx_dbm), got.company_code, got.name_length);
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN) begin
						$display("mismatch at cycle %0d", cycles);
						$display("  expected sum=%0b char=%02h flags=%02h pwr=%0d co=%04h len=%0d last=%0b",
							want.is_summary, want.name_char, want.flags_value,
							$signed(want.tx_dbm), want.company_code, want.name_length,
							want.last_result);
						$display("  actual   sum=%0b char=%02h flags=%02h pwr=%0d co=%04h len=%0d last=%0b",
							got.is_summary, got.name_char, got.flags_value,
							$signed(got.tx_dbm), got.company_code, got.name_length,
							got.last_result);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				due_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------
	// valid is left high after acceptance so the next request can follow at
	// once; ad_release drops it when nothing follows
	task automatic send_request(input ad_item_t it);
		@(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			ad_if.valid <= 1'b0;
			@(negedge clk);
		end
		ad_if.valid        <= 1'b1;
		ad_if.ad_byte      <= it.b;
		ad_if.last_byte    <= it.lst;
		ad_if.empty_report <= it.emp;
		@(posedge clk);
		while (!ad_if.ready) @(posedge clk);
		predict_request(it);
		if (!it.emp) bytes_sent++;
	endtask

	task automatic ad_release();
		@(negedge clk);
		ad_if.valid <= 1'b0;
	endtask

	task automatic send_report();
		foreach (stage_q[i]) send_request(stage_q[i]);
		reports_sent++;
		stage_q.delete();
	endtask

	// all results in, then wait for the drain to settle
	task automatic wait_idle();
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t v);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= v;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		apply_reg(idx, v);
		reg_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic void stage(input logic [7:0] b, input logic lst, input logic emp);
		ad_item_t it;
		it.b   = b;
		it.lst = lst;
		it.emp = emp;
		stage_q.push_back(it);
	endfunction

	function automatic void stage_bytes(input byte_seq_t seq);
		foreach (seq[i]) stage(seq[i], 1'b0, 1'b0);
	endfunction

	// mark the final staged request as the end of the report
	function automatic void close_report();
		ad_item_t it;
		it = stage_q.pop_back();
		it.lst = 1'b1;
		stage_q.push_back(it);
	endfunction

	// mostly well formed structure chains, with truncation, early stop,
	// oversized lengths and stray empty requests mixed in
	function automatic void build_random_report();
		int n_fields;
		int dlen;
		int cut;
		logic [7:0] ftype;
		if ($urandom_range(0, 19) == 0) begin
			stage(8'($urandom), 1'b1, 1'b1);
			return;
		end
		n_fields = $urandom_range(1, 4);
		for (int s = 0; s < n_fields; s++) begin
			dlen = $urandom_range(0, 3);
			case ($urandom_range(0, 9))
			0, 1: ftype = AD_FLAGS;
			2: ftype = AD_TX_POWER;
			3, 4: ftype = AD_MFG_DATA;
			5, 6: begin
				ftype = $urandom_range(0, 1) ? AD_NAME_FULL : AD_NAME_SHORT;
				// now and then a name long enough to be cut short
				dlen = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36)
					: $urandom_range(0, 6);
			end
			7: begin
				ftype = 8'($urandom);
				dlen = 0;
			end
			default: begin
				ftype = 8'($urandom);
				dlen = $urandom_range(0, 8);
			end
			endcase
			stage(8'(dlen + 1), 1'b0, 1'b0);
			stage(ftype, 1'b0, 1'b0);
			repeat (dlen) stage(8'($urandom), 1'b0, 1'b0);
			if ($urandom_range(0, 15) == 0) stage(8'($urandom), 1'b0, 1'b1);
		end
		case ($urandom_range(0, 9))
		0: begin
			// zero length, then bytes that must be ignored
			stage(8'h00, 1'b0, 1'b0);
			repeat ($urandom_range(0, 3)) stage(8'($urandom), 1'b0, 1'b0);
		end
		1: begin
			cut = $urandom_range(1, stage_q.size() - 1);
			repeat (cut) void'(stage_q.pop_back());
		end
		2: begin
			// structure claims far more bytes than the report holds
			stage(8'($urandom_range(240, 255)), 1'b0, 1'b0);
			stage(8'($urandom), 1'b0, 1'b0);
			repeat ($urandom_range(0, 3)) stage(8'($urandom), 1'b0, 1'b0);
		end
		default: ;
		endcase
		if ($urandom_range(0, 11) == 0)
			stage(8'($urandom), 1'b1, 1'b1);
		else
			close_report();
	endfunction

	function automatic cfg_data_t pick_value(input int width);
		cfg_data_t v;
		case ($urandom_range(0, 3))
		0: v = '0;
		1: v = '1;
		default: v = cfg_data_t'($urandom);
		endcase
		if (width == 8) v[15:8] = '0;
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_directed_parse();
		// empty report: defaults only
		stage(8'hFF, 1'b1, 1'b1);
		send_report();
		// flags, power -128, stray empty request, company, name, stop + junk
		stage_bytes('{8'h02, AD_FLAGS, 8'hFF, 8'h02, AD_TX_POWER, 8'h80});
		stage(8'h00, 1'b0, 1'b1);
		stage_bytes('{8'h03, AD_MFG_DATA, 8'h34, 8'h12, 8'h03, AD_NAME_FULL,
			8'h41, 8'h42, 8'h00, 8'hAA});
		close_report();
		send_report();
		// empty name skipped; next name runs past the end of the report
		stage_bytes('{8'h01, AD_NAME_FULL, 8'h05, AD_NAME_SHORT, 8'h61, 8'h62});
		close_report();
		send_report();
		// power 127, company with one byte only, length byte last
		stage_bytes('{8'h02, AD_TX_POWER, 8'h7F, 8'h02, AD_MFG_DATA, 8'h10, 8'h07});
		close_report();
		send_report();
		ad_release();
		wait_idle();
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_FLAGS_DEF, 16'h00FF);
		write_reg(CFG_POWER_DEF, 16'h0080);
		write_reg(CFG_COMPANY_DEF, 16'h0000);
		stage(8'h00, 1'b1, 1'b1);
		stage_bytes('{8'h02, AD_NAME_FULL, 8'h7E});
		close_report();
		send_report();
		ad_release();
		wait_idle();
		write_reg(CFG_FLAGS_DEF, 16'h0000);
		write_reg(CFG_POWER_DEF, 16'h007F);
		write_reg(CFG_COMPANY_DEF, 16'hFFFF);
		stage(8'h55, 1'b1, 1'b1);
		send_report();
		ad_release();
		wait_idle();
	endtask

	task automatic test_random_reports(input int n_bytes);
		int goal;
		int n_writes;
		goal = bytes_sent + n_bytes;
		while (bytes_sent < goal) begin
			build_random_report();
			send_report();
			// change the defaults between reports now and then
			if ($urandom_range(0, 3) == 0) begin
				ad_release();
				wait_idle();
				n_writes = $urandom_range(1, 3);
				repeat (n_writes) begin
					case ($urandom_range(0, 2))
					0: write_reg(CFG_FLAGS_DEF, pick_value(8));
					1: write_reg(CFG_POWER_DEF, pick_value(8));
					default: write_reg(CFG_COMPANY_DEF, pick_value(16));
					endcase
				end
			end
		end
		ad_release();
		wait_idle();
	endtask

	task automatic test_burst_reports(input int n_bytes);
		int goal;
		goal = bytes_sent + n_bytes;
		no_gaps = 1'b1;
		while (bytes_sent < goal) begin
			build_random_report();
			send_report();
		end
		ad_release();
		wait_idle();
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n             = 1'b0;
		ad_if.valid        = 1'b0;
		ad_if.ad_byte      = '0;
		ad_if.last_byte    = 1'b0;
		ad_if.empty_report = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = CFG_FLAGS_DEF;
		cfg_if.data        = '0;
		dflt_flags         = 8'h00;
		dflt_power         = 8'h7F;
		dflt_company       = 16'hFFFF;
		open_report();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_parse();
		test_register_extremes();
		test_random_reports(90);
		test_burst_reports(20);

		wait_idle();
		repeat (16) @(posedge clk);
		$display("covered %0d reports, %0d data bytes, %0d register writes",
			reports_sent, bytes_sent, reg_writes);
		$display("checked %0d results, %0d mismatches, %0d predictions left",
			results_seen, mismatches, due_results.size());
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule : ble_adv_data_field_extractor_core_tb

// ===== files.f =====
hw/rtl/bleadv_pkg.sv
hw/rtl/bleadv_if.sv
hw/rtl/ble_adv_data_field_extractor_core.sv
hw/rtl/bleadv_checker.sv
tb/ble_adv_data_field_extractor_core_tb.sv
